>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Attribute after reset
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Teletype control characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input commands
  typedef enum logic [1:0] {
    CMD_TELETYPE = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  // Store operations handed to the back end
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     scroll;
  } op_flags_t;

  // Cursor and scroll status reported with each result
  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    logic       scrolled;
  } res_meta_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR
  } back_state_t;

endpackage

>>> hw/rtl/tcw_front.sv
module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_char_code,
  input  logic [6:0]        in_column,
  input  logic [4:0]        in_row,
  input  logic [7:0]        in_fg,
  input  logic [7:0]        in_bg,
  output logic              op_push,
  output op_flags_t         op_flags,
  output res_meta_t         op_meta,
  output logic [ADDR_W-1:0] op_addr,
  output logic [15:0]       op_data
);

  logic [7:0] attr_r;
  logic [4:0] cur_row_r, cur_row_nxt;
  logic [6:0] cur_col_r, cur_col_nxt;
  logic [5:0] row_inc;
  logic       bottom;
  logic       in_range;
  logic       scroll;
  logic [ADDR_W-1:0] cursor_addr;
  logic [ADDR_W-1:0] target_addr;

  // Hold the attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  assign row_inc  = {1'b0, cur_row_r} + 6'd1;
  assign bottom   = row_inc >= 6'(ROWS);
  assign in_range = ({1'b0, in_column} < 8'(COLUMNS)) && ({1'b0, in_row} < 6'(ROWS));

  assign cursor_addr = ADDR_W'(ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_r));
  assign target_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLUMNS) + ADDR_W'(in_column));

  // Classify the request and advance the cursor
  always_comb begin
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    scroll         = 1'b0;
    op_flags.kind  = OP_NONE;
    op_addr        = target_addr;
    op_data        = {in_fg | in_bg, in_char_code};
    case (cmd_t'(in_command))
      CMD_TELETYPE: begin
        op_addr = cursor_addr;
        op_data = {attr_r, in_char_code};
        if (in_char_code == CHAR_RETURN) begin
          cur_col_nxt = '0;
        end else begin
          if (in_char_code != CHAR_NEWLINE) begin
            op_flags.kind = OP_WRITE;
          end
          if (in_char_code == CHAR_NEWLINE || cur_col_r >= 7'(COLUMNS - 1)) begin
            cur_col_nxt = '0;
            if (bottom) begin
              scroll      = 1'b1;
              cur_row_nxt = 5'(ROWS - 1);
            end else begin
              cur_row_nxt = row_inc[4:0];
            end
          end else begin
            cur_col_nxt = cur_col_r + 7'd1;
          end
        end
      end
      CMD_WRITE: begin
        if (in_range) begin
          op_flags.kind = OP_WRITE;
        end
      end
      CMD_CLEAR: begin
        op_flags.kind = OP_CLEAR;
        op_data       = {attr_r, 8'h00};
      end
      CMD_READ: begin
        if (in_range) begin
          op_flags.kind = OP_READ;
        end
      end
      default: begin
        op_flags.kind = OP_NONE;
      end
    endcase
    op_flags.scroll       = scroll;
    op_meta.cursor_row    = cur_row_nxt;
    op_meta.cursor_column = cur_col_nxt;
    op_meta.scrolled      = scroll;
  end

  assign op_push = in_valid;

  // Advance the cursor on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else if (in_valid) begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

endmodule

>>> hw/rtl/tcw_queue.sv
module tcw_queue
  import tcw_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DW-1:0]    entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign full    = count_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/tcw_back.sv
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  op_flags_t         q_flags,
  input  res_meta_t         q_meta,
  input  logic [ADDR_W-1:0] q_addr,
  input  logic [15:0]       q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       out_cell_value,
  output res_meta_t         out_meta
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [ADDR_W-1:0] SHIFT_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_r;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  res_meta_t         meta_r, meta_nxt;
  logic [15:0]       fill_r, fill_nxt;

  logic              out_vld_r;
  logic [15:0]       out_cell_r;
  res_meta_t         out_meta_r;
  logic              out_free;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;
  logic              res_push;
  logic [15:0]       res_cell;
  res_meta_t         res_meta;

  assign out_free = !out_vld_r || pop;

  // Sequence store operations
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    meta_nxt  = meta_r;
    fill_nxt  = fill_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = q_addr;
    wdata     = q_data;
    raddr     = q_addr;
    res_push  = 1'b0;
    res_cell  = '0;
    res_meta  = meta_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop    = 1'b1;
          meta_nxt = q_meta;
          res_meta = q_meta;
          cnt_nxt  = '0;
          case (q_flags.kind)
            OP_WRITE, OP_NONE: begin
              we = q_flags.kind == OP_WRITE;
              if (q_flags.scroll) begin
                state_nxt = ST_SCROLL;
              end else begin
                res_push = 1'b1;
              end
            end
            OP_READ: begin
              state_nxt = ST_READ;
            end
            OP_CLEAR: begin
              fill_nxt  = q_data;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push  = 1'b1;
        res_cell  = rdata_r;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row ahead, write the previous cell one row up
        we    = cnt_r != '0;
        waddr = cnt_r - ADDR_W'(1);
        wdata = rdata_r;
        raddr = cnt_r + ADDR_W'(COLUMNS);
        if (cnt_r == SHIFT_LAST) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = '0;
        if (cnt_r == CELL_LAST) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = fill_r;
        if (cnt_r == CELL_LAST) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    meta_r <= meta_nxt;
    fill_r <= fill_nxt;
  end

  // Cell store with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Hold the finished result until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_push) begin
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_cell_r <= res_cell;
      out_meta_r <= res_meta;
    end
  end

  assign empty          = !out_vld_r;
  assign out_cell_value = out_cell_r;
  assign out_meta       = out_meta_r;

endmodule

>>> hw/rtl/text_console_writer.sv
// Text console writer over a COLUMNS x ROWS store of 16-bit cells
// (attribute in the high byte, character in the low byte).
// Input channel: a request is taken when push is high and full is low.
// Command 0 prints a character at the cursor (newline, carriage return,
// wrap and scroll handled), 1 writes a cell, 2 clears, 3 reads a cell.
// Result channel: one result per request, in order; it is shown while
// empty is low and taken when pop is high. cfg_we writes the attribute
// used for printing and clearing; write it only while the block is idle.
// A request is stored in the queue, popped by the sequencer and its result
// registered; a read also passes the read state, since the cell store read
// is registered. Writes and prints that do not scroll sustain one per cycle
// while results are popped; a read holds the sequencer until its result is
// out. A scroll copies one cell a cycle, then blanks the last row, a clear
// writes one cell a cycle; up to four requests queue up meanwhile before full rises.
// Reset puts the cursor at row 0, column 0 and the attribute at 0x0F;
// the cell store is undefined until written. When the receiver stalls,
// the result is held, then the internal queue fills and full rises.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_column,
  input  logic [4:0] in_row,
  input  logic [7:0] in_fg,
  input  logic [7:0] in_bg,
  output logic       empty,
  input  logic       pop,
  output logic [15:0] out_cell_value,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_column,
  output logic       out_scrolled
);

  localparam int ADDR_W = $clog2(COLUMNS * ROWS);
  localparam int QW     = $bits(op_flags_t) + $bits(res_meta_t) + ADDR_W + 16;

  logic              op_push;
  op_flags_t         op_flags, q_flags;
  res_meta_t         op_meta, q_meta, out_meta;
  logic [ADDR_W-1:0] op_addr, q_addr;
  logic [15:0]       op_data, q_data;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_pop, q_empty, q_full;

  assign full = q_full;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (push && !q_full),
    .in_command  (in_command),
    .in_char_code(in_char_code),
    .in_column   (in_column),
    .in_row      (in_row),
    .in_fg       (in_fg),
    .in_bg       (in_bg),
    .op_push     (op_push),
    .op_flags    (op_flags),
    .op_meta     (op_meta),
    .op_addr     (op_addr),
    .op_data     (op_data)
  );

  assign q_wdata = {op_flags, op_meta, op_addr, op_data};
  assign {q_flags, q_meta, q_addr, q_data} = q_rdata;

  tcw_queue #(
    .DW(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (op_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_flags       (q_flags),
    .q_meta        (q_meta),
    .q_addr        (q_addr),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_cell_value(out_cell_value),
    .out_meta      (out_meta)
  );

  assign out_cursor_row    = out_meta.cursor_row;
  assign out_cursor_column = out_meta.cursor_column;
  assign out_scrolled      = out_meta.scrolled;

endmodule

>>> test/tcw_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the console writer, keeps its own copy of the
// screen, cursor and attribute, and checks every reply against it.
module tcw_checker
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_fg,
  input  logic [7:0]  in_bg,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_cell_value,
  input  logic [4:0]  out_cursor_row,
  input  logic [6:0]  out_cursor_column,
  input  logic        out_scrolled,
  output int          mismatches,
  output int          waiting
);

  localparam int CELLS = DEF_COLUMNS * DEF_ROWS;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } console_reply_t;

  logic [15:0]    screen [CELLS];
  logic [4:0]     cur_row;
  logic [6:0]     cur_col;
  logic [7:0]     text_attr;
  console_reply_t pending_replies [$];
  int             reply_index;

  // Shift every line up by one and blank the bottom line
  function automatic void scroll_screen();
    int i;
    for (i = 0; i < CELLS - DEF_COLUMNS; i++) begin
      screen[i] = screen[i + DEF_COLUMNS];
    end
    for (i = CELLS - DEF_COLUMNS; i < CELLS; i++) begin
      screen[i] = '0;
    end
  endfunction

  // Move to the start of the next line; scroll when leaving the bottom line
  function automatic logic advance_line();
    cur_col = '0;
    if (int'(cur_row) + 1 >= DEF_ROWS) begin
      scroll_screen();
      cur_row = 5'(DEF_ROWS - 1);
      return 1'b1;
    end
    cur_row = cur_row + 5'd1;
    return 1'b0;
  endfunction

  // Print one character at the cursor, handling control codes and wrap
  function automatic logic print_char(logic [7:0] ch);
    if (ch == CHAR_NEWLINE) begin
      return advance_line();
    end
    if (ch == CHAR_RETURN) begin
      cur_col = '0;
      return 1'b0;
    end
    screen[int'(cur_row) * DEF_COLUMNS + int'(cur_col)] = {text_attr, ch};
    if (int'(cur_col) < DEF_COLUMNS - 1) begin
      cur_col = cur_col + 7'd1;
      return 1'b0;
    end
    return advance_line();
  endfunction

  // Apply one request to the screen copy and form the reply it causes
  function automatic console_reply_t predict_reply(cmd_t cmd, logic [7:0] ch,
                                                   logic [6:0] col, logic [4:0] row,
                                                   logic [7:0] fg, logic [7:0] bg);
    console_reply_t reply;
    logic           hit;
    int             addr;
    int             i;
    reply = '0;
    hit   = (int'(col) < DEF_COLUMNS) && (int'(row) < DEF_ROWS);
    addr  = int'(row) * DEF_COLUMNS + int'(col);
    case (cmd)
      CMD_TELETYPE: begin
        reply.scrolled = print_char(ch);
      end
      CMD_WRITE: begin
        if (hit) screen[addr] = {fg | bg, ch};
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {text_attr, 8'h00};
      end
      default: begin
        if (hit) reply.cell_value = screen[addr];
      end
    endcase
    reply.cursor_row    = cur_row;
    reply.cursor_column = cur_col;
    return reply;
  endfunction

  task automatic report_failure(string what, console_reply_t want, console_reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] reply %0d %s: want cell %h row %0d col %0d scroll %b,",
               $realtime, reply_index, what,
               want.cell_value, want.cursor_row, want.cursor_column, want.scrolled);
      $display("    got cell %h row %0d col %0d scroll %b",
               got.cell_value, got.cursor_row, got.cursor_column, got.scrolled);
    end
  endtask

  // Track configuration, compare replies, then queue the new prediction
  always @(posedge clk) begin : track
    console_reply_t got;
    console_reply_t want;
    if (!rst_n) begin
      cur_row   = '0;
      cur_col   = '0;
      text_attr = ATTR_RESET;
      pending_replies.delete();
    end else begin
      if (cfg_we) text_attr = cfg_wdata;
      if (pop && !empty) begin
        got = {out_cell_value, out_cursor_row, out_cursor_column, out_scrolled};
        if (pending_replies.size() == 0) begin
          report_failure("unexpected", '0, got);
        end else begin
          want = pending_replies.pop_front();
          if (got.cell_value !== want.cell_value)
            report_failure("cell_value", want, got);
          else if (got.cursor_row !== want.cursor_row)
            report_failure("cursor_row", want, got);
          else if (got.cursor_column !== want.cursor_column)
            report_failure("cursor_column", want, got);
          else if (got.scrolled !== want.scrolled)
            report_failure("scrolled", want, got);
        end
        reply_index++;
      end
      if (push && !full) begin
        pending_replies.push_back(predict_reply(cmd_t'(in_command), in_char_code,
                                                in_column, in_row, in_fg, in_bg));
      end
    end
    waiting = pending_replies.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import tcw_pkg::*;
();

  localparam int LIMIT_CYCLES  = 12_000_000;
  localparam int PHASE_ITEMS   = 190;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = DEF_COLUMNS * DEF_ROWS + 100;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [7:0]  cfg_wdata    = '0;
  logic        push         = 1'b0;
  logic        full;
  cmd_t        in_command   = CMD_TELETYPE;
  logic [7:0]  in_char_code = '0;
  logic [6:0]  in_column    = '0;
  logic [4:0]  in_row       = '0;
  logic [7:0]  in_fg        = '0;
  logic [7:0]  in_bg        = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_column;
  logic        out_scrolled;

  int mismatch_count;
  int waiting_replies;
  int sent_count    = 0;
  int cycle_count   = 0;
  int pop_hold      = 0;
  bit send_idle_on  = 1'b0;
  bit recv_idle_on  = 1'b0;

  text_console_writer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_fg            (in_fg),
    .in_bg            (in_bg),
    .empty            (empty),
    .pop              (pop),
    .out_cell_value   (out_cell_value),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_column(out_cursor_column),
    .out_scrolled     (out_scrolled)
  );

  tcw_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_fg            (in_fg),
    .in_bg            (in_bg),
    .empty            (empty),
    .pop              (pop),
    .out_cell_value   (out_cell_value),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_column(out_cursor_column),
    .out_scrolled     (out_scrolled),
    .mismatches       (mismatch_count),
    .waiting          (waiting_replies)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("text_console_writer regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Result side: stall pop at random while idling is enabled
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (recv_idle_on && $urandom_range(0, 99) < 30) begin
      pop <= 1'b0;
      pop_hold = pick_gap();
    end else begin
      pop <= 1'b1;
    end
  end

  // Present one request, hold it until taken, then maybe idle
  task automatic send_request(input cmd_t cmd, input logic [7:0] ch, input logic [6:0] col,
                              input logic [4:0] row, input logic [7:0] fg,
                              input logic [7:0] bg);
    int gap;
    @(negedge clk);
    push         <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_column    <= col;
    in_row       <= row;
    in_fg        <= fg;
    in_bg        <= bg;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_count++;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_print(input logic [7:0] ch);
    send_request(CMD_TELETYPE, ch, 7'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop push, wait for every reply, then let a scroll or clear finish
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    @(posedge clk);
    while (waiting_replies != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random burst: a text line, cell accesses, noise, blank lines or a clear
  task automatic run_burst();
    int         kind;
    int         n;
    logic [6:0] col;
    logic [4:0] row;
    cmd_t       cmd;
    kind = $urandom_range(0, 99);
    if (kind < 42) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(78, 90) : $urandom_range(0, 20);
      repeat (n) send_print(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 9);
      if (n < 7) send_print(CHAR_NEWLINE);
      else if (n < 9) send_print(CHAR_RETURN);
    end else if (kind < 77) begin
      repeat ($urandom_range(1, 8)) begin
        col = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(DEF_COLUMNS, 127))
                                          : 7'($urandom_range(0, DEF_COLUMNS - 1));
        row = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(DEF_ROWS, 31))
                                          : 5'($urandom_range(0, DEF_ROWS - 1));
        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        send_request(cmd, 8'($urandom), col, row, 8'($urandom), 8'($urandom));
      end
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_TELETYPE;
          1:       cmd = CMD_WRITE;
          default: cmd = CMD_READ;
        endcase
        send_request(cmd, 8'($urandom), 7'($urandom), 5'($urandom), 8'($urandom),
                     8'($urandom));
      end
    end else if (kind < 97) begin
      repeat ($urandom_range(1, 6)) send_print(CHAR_NEWLINE);
    end else begin
      send_request(CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 8'($urandom),
                   8'($urandom));
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: define every cell first, then corners, out-of-range and controls
    send_request(CMD_CLEAR,    8'h00, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_WRITE,    8'h00, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_WRITE,    8'hFF, 7'd79,  5'd24, 8'hF0, 8'h0F);
    send_request(CMD_WRITE,    8'hAA, 7'd80,  5'd0,  8'h55, 8'h00);
    send_request(CMD_WRITE,    8'h55, 7'd127, 5'd31, 8'hFF, 8'hFF);
    send_request(CMD_WRITE,    8'h33, 7'd0,   5'd25, 8'h12, 8'h34);
    send_request(CMD_READ,     8'hFF, 7'd0,   5'd0,  8'hFF, 8'hFF);
    send_request(CMD_READ,     8'h00, 7'd79,  5'd24, 8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd80,  5'd0,  8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd127, 5'd31, 8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd0,   5'd25, 8'h00, 8'h00);
    send_request(CMD_TELETYPE, 8'h00, 7'd127, 5'd31, 8'hFF, 8'hFF);
    send_request(CMD_TELETYPE, 8'hFF, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_TELETYPE, 8'h41, 7'd5,   5'd5,  8'h5A, 8'hA5);
    send_request(CMD_TELETYPE, CHAR_RETURN,  7'd0, 5'd0, 8'h00, 8'h00);
    send_request(CMD_TELETYPE, 8'h42, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_TELETYPE, CHAR_NEWLINE, 7'd0, 5'd0, 8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd0,   5'd0,  8'h00, 8'h00);
    send_request(CMD_READ,     8'h00, 7'd2,   5'd0,  8'h00, 8'h00);
    send_request(CMD_CLEAR,    8'hFF, 7'd127, 5'd31, 8'hFF, 8'hFF);
    send_request(CMD_READ,     8'h00, 7'd40,  5'd12, 8'h00, 8'h00);

    // Random phases, each under its own attribute and idling mix
    for (phase = 1; phase <= PHASES; phase++) begin
      settle();
      case (phase)
        1:       write_attribute(8'h00);
        2:       write_attribute(8'hFF);
        PHASES:  write_attribute(ATTR_RESET);
        default: write_attribute(8'($urandom_range(0, 255)));
      endcase
      if (phase == 1) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
      end else if (phase == 2) begin
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
      end else begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
      end
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) run_burst();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
